@@ rtl/cfsws_pkg.sv @@
// shared types, constants and helper functions for the framed crc sender
// no dependencies; imported by every module of the block
`default_nettype none

package cfsws_pkg;

    localparam int DEF_BUFFER_DEPTH = 4096;
    localparam int CHUNK_CAP        = 4082;
    localparam int FILL_W           = 12;
    localparam int PTR_W            = 13;
    localparam int ADDR_W           = 4;
    localparam int DATA_W           = 32;
    localparam int HDR_LEN          = 12;
    localparam int FRAME_EXTRA      = 14;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] MS_MAX   = 16'hFFFF;

    localparam logic [7:0] ACK_OK_A = 8'h05;
    localparam logic [7:0] ACK_OK_B = 8'hFD;
    localparam logic [7:0] ACK_NAK  = 8'h04;

    localparam logic [1:0] NAK_REPEATS     = 2'd2;
    localparam logic [1:0] TIMEOUT_REPEATS = 2'd3;

    // register index within the apb map
    localparam logic [1:0] REG_CHUNK   = 2'd0;
    localparam logic [1:0] REG_RESEND  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    localparam logic [11:0] RST_CHUNK   = 12'd4082;
    localparam logic [15:0] RST_RESEND  = 16'd600;
    localparam logic [15:0] RST_TIMEOUT = 16'd3000;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_PULL = 2'd1,
        OP_ACK  = 2'd2,
        OP_TICK = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        PH_LOAD    = 3'd0,
        PH_READY   = 3'd1,
        PH_SEND    = 3'd2,
        PH_WAIT    = 3'd3,
        PH_ACCEPT  = 3'd4,
        PH_RESEND  = 3'd5,
        PH_NAK     = 3'd6,
        PH_TIMEOUT = 3'd7
    } t_phase;

    typedef struct packed {
        logic [FILL_W-1:0] chunk_lim;
        logic [15:0]       resend_ms;
        logic [15:0]       timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       frame_last;
        t_phase     status;
        logic       from_mem;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // fixed 8-byte prefix shared by data and exit frames, last byte differs
    function automatic logic [7:0] prefix_byte(input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd0: b = 8'h3A;
            3'd1: b = 8'hA1;
            3'd2: b = 8'hBB;
            3'd3: b = 8'h44;
            3'd4: b = 8'h7F;
            3'd5: b = 8'hFF;
            3'd6: b = 8'hFE;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] exit_byte(input logic [3:0] pos);
        logic [7:0] b;
        unique case (pos)
            4'd0: b = 8'h3A;
            4'd1: b = 8'hA1;
            4'd2: b = 8'hBB;
            4'd3: b = 8'h44;
            4'd4: b = 8'h7F;
            4'd5: b = 8'hFF;
            4'd6: b = 8'hFE;
            4'd7: b = 8'h00;
            4'd8: b = 8'hFF;
            4'd9: b = 8'hFF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cfsws_store.sv @@
// frame payload memory: one write port, one read port with registered data
// uses cfsws_pkg for the default depth
`default_nettype none

module cfsws_store
    import cfsws_pkg::*;
#(
    parameter int DEPTH = DEF_BUFFER_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [7:0]               i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [7:0]               o_rd_data
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read so a stalled result keeps its byte
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/cfsws_ctrl.sv @@
// sender control: phase, fill count, crc, frame id, timers, readout pointer
// drives the frame memory ports; uses cfsws_pkg types and functions
`default_nettype none

module cfsws_ctrl
    import cfsws_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_go,
    input  wire logic [1:0]                      i_op,
    input  wire logic [7:0]                      i_data_byte,
    input  wire logic                            i_end_of_file,
    input  wire logic [7:0]                      i_ack_byte,
    input  wire t_cfg                            i_cfg,
    output logic                                 o_wr_en,
    output logic      [$clog2(BUFFER_DEPTH)-1:0] o_wr_addr,
    output logic      [7:0]                      o_wr_data,
    output logic                                 o_rd_en,
    output logic      [$clog2(BUFFER_DEPTH)-1:0] o_rd_addr,
    output t_result                              o_res
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    t_phase            r_phase, n_phase;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [15:0]       r_crc, n_crc;
    logic [15:0]       r_frame_id, n_frame_id;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [15:0]       r_since_send, n_since_send;
    logic [15:0]       r_since_start, n_since_start;
    logic [1:0]        r_repeats, n_repeats;
    logic              r_final, n_final;

    t_op              op;
    logic [PTR_W-1:0] rp_inc;
    logic [PTR_W-1:0] frame_end;
    logic [PTR_W-1:0] pay_off;
    logic [PTR_W-1:0] fill_inc;
    logic [15:0]      len;
    logic [15:0]      send_inc, start_inc, rs_lim, to_lim;
    logic             in_frame_phase, in_exit_phase, in_ack_phase;
    logic             is_load, load_close;
    logic             pull_frame, frame_done, pull_exit, exit_wrap, exit_done;
    logic             ack_ok, ack_nak, tick_live, resend_hit, timeout_hit;
    logic             payload_rd;

    assign op             = t_op'(i_op);
    assign in_frame_phase = (r_phase == PH_READY) || (r_phase == PH_SEND)
                            || (r_phase == PH_RESEND);
    assign in_exit_phase  = (r_phase == PH_NAK) || (r_phase == PH_TIMEOUT);
    assign in_ack_phase   = (r_phase == PH_WAIT) || (r_phase == PH_RESEND);

    assign rp_inc    = r_rp + PTR_W'(1);
    assign frame_end = PTR_W'(r_fill) + PTR_W'(FRAME_EXTRA);
    assign pay_off   = r_rp - PTR_W'(HDR_LEN);
    assign fill_inc  = PTR_W'(r_fill) + PTR_W'(1);
    assign len       = 16'(r_fill) + 16'd2;
    assign send_inc  = (r_since_send == MS_MAX) ? MS_MAX : r_since_send + 16'd1;
    assign start_inc = (r_since_start == MS_MAX) ? MS_MAX : r_since_start + 16'd1;
    assign rs_lim    = (i_cfg.resend_ms == 16'd0) ? 16'd1 : i_cfg.resend_ms;
    assign to_lim    = (i_cfg.timeout_ms == 16'd0) ? 16'd1 : i_cfg.timeout_ms;

    assign is_load     = i_go && (op == OP_LOAD) && (r_phase == PH_LOAD);
    assign load_close  = is_load && ((fill_inc >= PTR_W'(i_cfg.chunk_lim)) || i_end_of_file);
    assign pull_frame  = i_go && (op == OP_PULL) && in_frame_phase;
    assign frame_done  = pull_frame && (rp_inc >= frame_end);
    assign pull_exit   = i_go && (op == OP_PULL) && in_exit_phase;
    assign exit_wrap   = pull_exit && (rp_inc >= PTR_W'(HDR_LEN));
    assign exit_done   = exit_wrap && (r_repeats <= 2'd1);
    assign ack_ok      = i_go && (op == OP_ACK) && in_ack_phase
                         && ((i_ack_byte == ACK_OK_A) || (i_ack_byte == ACK_OK_B));
    assign ack_nak     = i_go && (op == OP_ACK) && in_ack_phase && (i_ack_byte == ACK_NAK);
    assign tick_live   = i_go && (op == OP_TICK) && in_ack_phase;
    assign resend_hit  = tick_live && (r_phase == PH_WAIT) && (send_inc >= rs_lim);
    assign timeout_hit = tick_live && (start_inc >= to_lim);

    // payload region of the readout comes from the memory
    assign payload_rd = pull_frame && (r_rp >= PTR_W'(HDR_LEN)) && (pay_off < PTR_W'(r_fill));

    assign o_wr_en   = is_load;
    assign o_wr_addr = AW'(r_fill);
    assign o_wr_data = i_data_byte;
    assign o_rd_en   = payload_rd;
    assign o_rd_addr = AW'(pay_off);

    // next phase; a timeout wins over a resend on the same tick
    always_comb begin
        n_phase = r_phase;
        priority if (load_close) begin
            n_phase = PH_READY;
        end else if (frame_done) begin
            n_phase = PH_WAIT;
        end else if (pull_frame && (r_phase == PH_READY)) begin
            n_phase = PH_SEND;
        end else if (exit_done || ack_ok) begin
            n_phase = PH_LOAD;
        end else if (ack_nak) begin
            n_phase = PH_NAK;
        end else if (timeout_hit) begin
            n_phase = PH_TIMEOUT;
        end else if (resend_hit) begin
            n_phase = PH_RESEND;
        end else begin
            n_phase = r_phase;
        end
    end

    // frame datapath and timers
    always_comb begin
        n_fill        = r_fill;
        n_crc         = r_crc;
        n_final       = r_final;
        n_rp          = r_rp;
        n_frame_id    = r_frame_id;
        n_since_send  = r_since_send;
        n_since_start = r_since_start;
        n_repeats     = r_repeats;

        if (ack_ok || exit_done) begin
            n_fill  = '0;
            n_crc   = CRC_INIT;
            n_final = 1'b0;
        end else if (is_load) begin
            n_fill = FILL_W'(fill_inc);
            n_crc  = crc_byte(r_crc, i_data_byte);
            if (load_close) begin
                n_final = i_end_of_file;
            end
        end

        if (load_close || frame_done || exit_wrap || ack_ok || ack_nak
            || resend_hit || timeout_hit) begin
            n_rp = '0;
        end else if (pull_frame || pull_exit) begin
            n_rp = rp_inc;
        end

        if (exit_done) begin
            n_frame_id = '0;
        end else if (ack_ok) begin
            n_frame_id = r_final ? 16'd0 : r_frame_id + 16'd1;
        end

        if (frame_done) begin
            n_since_send = '0;
        end else if (tick_live && (r_phase == PH_WAIT)) begin
            n_since_send = send_inc;
        end

        // only a first send restarts the transfer timer
        if (frame_done && (r_phase != PH_RESEND)) begin
            n_since_start = '0;
        end else if (tick_live) begin
            n_since_start = start_inc;
        end

        if (ack_nak) begin
            n_repeats = NAK_REPEATS;
        end else if (timeout_hit) begin
            n_repeats = TIMEOUT_REPEATS;
        end else if (exit_wrap && (r_repeats != 2'd0)) begin
            n_repeats = r_repeats - 2'd1;
        end
    end

    // result of the item
    always_comb begin
        o_res            = '0;
        o_res.frame_last = frame_done || exit_done;
        o_res.from_mem   = payload_rd;
        if (ack_ok) begin
            o_res.status = PH_ACCEPT;
        end else if (pull_exit) begin
            o_res.status = r_phase;
        end else begin
            o_res.status = n_phase;
        end
        if (pull_exit) begin
            o_res.tx_valid = 1'b1;
            o_res.tx_byte  = (r_rp < PTR_W'(HDR_LEN)) ? exit_byte(r_rp[3:0]) : exit_byte(4'd0);
        end else if (pull_frame) begin
            o_res.tx_valid = 1'b1;
            priority if (r_rp < PTR_W'(8)) begin
                o_res.tx_byte = prefix_byte(r_rp[2:0]);
            end else if (r_rp == PTR_W'(8)) begin
                o_res.tx_byte = r_frame_id[7:0];
            end else if (r_rp == PTR_W'(9)) begin
                o_res.tx_byte = r_frame_id[15:8];
            end else if (r_rp == PTR_W'(10)) begin
                o_res.tx_byte = len[7:0];
            end else if (r_rp == PTR_W'(11)) begin
                o_res.tx_byte = len[15:8];
            end else if (payload_rd) begin
                o_res.tx_byte = 8'h00;
            end else if (pay_off == PTR_W'(r_fill)) begin
                o_res.tx_byte = r_crc[7:0];
            end else begin
                o_res.tx_byte = r_crc[15:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_LOAD;
            r_fill        <= '0;
            r_crc         <= CRC_INIT;
            r_frame_id    <= '0;
            r_rp          <= '0;
            r_since_send  <= '0;
            r_since_start <= '0;
            r_repeats     <= '0;
            r_final       <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_fill        <= n_fill;
            r_crc         <= n_crc;
            r_frame_id    <= n_frame_id;
            r_rp          <= n_rp;
            r_since_send  <= n_since_send;
            r_since_start <= n_since_start;
            r_repeats     <= n_repeats;
            r_final       <= n_final;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cfsws_out.sv @@
// result pipeline: a stage that waits for the memory read, then the output register
// uses cfsws_pkg result type
`default_nettype none

module cfsws_out
    import cfsws_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_go,
    input  wire t_result    i_res,
    input  wire logic [7:0] i_mem_data,
    input  wire logic       i_out_stall,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output logic      [7:0] o_tx_byte,
    output logic            o_tx_valid,
    output logic            o_frame_last,
    output logic      [2:0] o_status
);

    logic    r_p_valid, n_p_valid;
    t_result r_p_res;
    t_result p_res_mem;
    logic    r_o_valid, n_o_valid;
    t_result r_o_res;
    logic    p_move;

    // the middle stage can take a new transfer while the output one waits
    assign p_move     = r_p_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_p_valid && !p_move;

    always_comb begin
        n_p_valid = r_p_valid;
        if (i_go) begin
            n_p_valid = 1'b1;
        end else if (p_move) begin
            n_p_valid = 1'b0;
        end
        n_o_valid = r_o_valid;
        if (p_move) begin
            n_o_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_o_valid = 1'b0;
        end
    end

    // payload bytes take their value from the memory read
    always_comb begin
        p_res_mem = r_p_res;
        if (r_p_res.from_mem) begin
            p_res_mem.tx_byte = i_mem_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_p_valid <= n_p_valid;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_p_res <= i_res;
        end
        if (p_move) begin
            r_o_res <= p_res_mem;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_tx_byte    = r_o_res.tx_byte;
    assign o_tx_valid   = r_o_res.tx_valid;
    assign o_frame_last = r_o_res.frame_last;
    assign o_status     = r_o_res.status;

endmodule

`default_nettype wire

@@ rtl/crc_framed_stop_and_wait_sender.sv @@
// Stop-and-wait framed sender with CRC-16/Modbus, top level.
// Input channel (i_in_valid / o_in_stall) carries one item per transfer: an op
// code of load file byte, pull transmit byte, acknowledgement byte or
// millisecond tick, with its data fields. Every item gives exactly one result
// on the output channel (o_out_valid / i_out_stall): tx byte, tx valid, frame
// last and the status code after the item.
// Throughput is one item per cycle while the output does not stall. An item's
// result passes through a middle stage, which waits for the registered read of
// the payload memory, and then the output register. A result held by a stalled
// receiver still lets one more item in; after that o_in_stall rises until the
// output moves on. Nothing is dropped or repeated.
// The registers chunk_payload, resend_ms and frame_timeout_ms sit on an APB
// port at byte addresses 0, 4 and 8; the user writes them only while idle, as the block does not enforce it.
// Synchronous reset returns to loading with frame id 0, an empty frame and
// the registers at their defaults; the payload memory is not cleared.
// depends on cfsws_pkg, cfsws_ctrl, cfsws_store and cfsws_out
`default_nettype none

module crc_framed_stop_and_wait_sender
    import cfsws_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_op,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_end_of_file,
    input  wire logic [7:0]        i_ack_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [7:0]        o_tx_byte,
    output logic                   o_tx_valid,
    output logic                   o_frame_last,
    output logic      [2:0]        o_status,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int AW        = $clog2(BUFFER_DEPTH);
    localparam int MAX_CHUNK = (BUFFER_DEPTH < CHUNK_CAP) ? BUFFER_DEPTH : CHUNK_CAP;

    logic [11:0] r_chunk_payload;
    logic [15:0] r_resend_ms;
    logic [15:0] r_frame_timeout_ms;

    logic          cfg_wr;
    logic [1:0]    cfg_idx;
    t_cfg          cfg;
    logic          go;
    logic          in_stall;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;
    t_result       res;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_payload    <= RST_CHUNK;
            r_resend_ms        <= RST_RESEND;
            r_frame_timeout_ms <= RST_TIMEOUT;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_CHUNK:   r_chunk_payload    <= pwdata[11:0];
                REG_RESEND:  r_resend_ms        <= pwdata[15:0];
                REG_TIMEOUT: r_frame_timeout_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_CHUNK:   prdata = DATA_W'(r_chunk_payload);
            REG_RESEND:  prdata = DATA_W'(r_resend_ms);
            REG_TIMEOUT: prdata = DATA_W'(r_frame_timeout_ms);
            default:     prdata = '0;
        endcase
    end

    // frame size limit clamped to 1 .. min(4082, memory depth)
    always_comb begin
        cfg = '0;
        if (r_chunk_payload == 12'd0) begin
            cfg.chunk_lim = FILL_W'(1);
        end else if (r_chunk_payload > 12'(MAX_CHUNK)) begin
            cfg.chunk_lim = FILL_W'(MAX_CHUNK);
        end else begin
            cfg.chunk_lim = r_chunk_payload;
        end
        cfg.resend_ms  = r_resend_ms;
        cfg.timeout_ms = r_frame_timeout_ms;
    end

    assign go         = i_in_valid && !in_stall;
    assign o_in_stall = in_stall;

    cfsws_ctrl #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (go),
        .i_op          (i_op),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .i_ack_byte    (i_ack_byte),
        .i_cfg         (cfg),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_res         (res)
    );

    cfsws_store #(
        .DEPTH(BUFFER_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cfsws_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_res        (res),
        .i_mem_data   (rd_data),
        .i_out_stall  (i_out_stall),
        .o_in_stall   (in_stall),
        .o_out_valid  (o_out_valid),
        .o_tx_byte    (o_tx_byte),
        .o_tx_valid   (o_tx_valid),
        .o_frame_last (o_frame_last),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire
